// File: sv/tcw_pkg.sv
package tcw_pkg;

  // geometry defaults
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  // field widths fixed by the cell format and command set
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int CMD_W  = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h07;

  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_COLOR, CH_SPACE};

endpackage

// File: sv/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = tcw_pkg::CELL_W,
  parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/text_console_writer_core.sv
// flow: one command in flight at a time; a beat is taken in idle, then decode, a blank sweep
//   over one row for a scroll or over all cells for a clear, a memory access for a printed
//   cell or a read on screen, read data capture for a read, and the result goes to the
//   output register; the sequencing is set by the single port of the cell memory
// reset: synchronous active-low rst_n; afterwards a clearing pass writes ROWS*COLUMNS
//   blank cells (one per cycle) before the first input beat is taken
module text_console_writer_core #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF,
  localparam int NCELLS  = COLUMNS * ROWS,
  localparam int COL_W   = $clog2(COLUMNS + 1),
  localparam int ROW_W   = $clog2(ROWS),
  localparam int IDX_W   = $clog2(NCELLS),
  localparam int IN_DW   = ((tcw_pkg::CHAR_W + IDX_W + 7) / 8) * 8,
  localparam int OUT_RAW = tcw_pkg::CELL_W + COL_W + ROW_W + 1,
  localparam int OUT_DW  = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration: text_color
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_data,
  // command stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_DW-1:0]          in_tdata,   // char_byte, cell_index, zero pad
  input  logic [tcw_pkg::CMD_W-1:0] in_tuser,   // cmd
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_DW-1:0]         out_tdata   // cell_data, cursor_col, cursor_row,
                                                // scrolled, zero pad
);

  localparam int TAB_W = $clog2(TAB_STOP);
  localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [TAB_W-1:0]  TAB_LAST = TAB_W'(TAB_STOP - 1);
  localparam logic [TAB_W-1:0]  TAB_END  = TAB_W'(COLUMNS % TAB_STOP);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(NCELLS - 1);

  typedef enum logic [2:0] {
    S_INIT,    // clearing pass after reset
    S_IDLE,    // waiting for a command beat
    S_DECODE,  // cursor update and logical cell position
    S_BLANK,   // blank sweep for scroll or clear
    S_ACCESS,  // memory write of a printed cell, or read issue
    S_RDATA,   // capture read data
    S_DONE     // hand result to the output register
  } state_t;

  state_t state_r, state_nxt;

  // cursor and screen state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [TAB_W-1:0] tph_r, tph_nxt;          // column modulo tab stop
  logic [IDX_W-1:0] base_r, base_nxt;        // physical offset of logical row 0
  logic [tcw_pkg::CELL_W-1:0] last_cell_r, last_cell_nxt;
  logic [7:0] color_r, color_nxt;

  // current command
  logic [tcw_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [tcw_pkg::CHAR_W-1:0] ch_r, ch_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [IDX_W-1:0]           lpos_r, lpos_nxt;
  logic                       rd_r, rd_nxt;
  logic                       go_access_r, go_access_nxt;
  logic                       scr_r, scr_nxt;
  logic [tcw_pkg::CELL_W-1:0] res_data_r, res_data_nxt;

  // blank sweep bounds
  logic [IDX_W-1:0] sweep_addr_r, sweep_addr_nxt;
  logic [IDX_W-1:0] sweep_last_r, sweep_last_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CELL_W-1:0] out_data_r, out_data_nxt;
  logic [COL_W-1:0]           out_col_r, out_col_nxt;
  logic [ROW_W-1:0]           out_row_r, out_row_nxt;
  logic                       out_scr_r, out_scr_nxt;

  // memory port
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_addr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  // decode helpers
  logic [IDX_W:0]   phys_sum;
  logic [IDX_W-1:0] phys_addr;
  logic [IDX_W:0]   base_sum;
  logic [IDX_W-1:0] base_adv;
  logic [COL_W:0]   tab_sum;
  logic             printable;
  logic             wrap;
  logic [COL_W-1:0] c0;
  logic [TAB_W-1:0] p0;
  logic             row_full;

  // logical position to physical cell: rotate by the row base
  assign phys_sum  = {1'b0, lpos_r} + {1'b0, base_r};
  assign phys_addr = (phys_sum >= (IDX_W+1)'(NCELLS)) ?
                     IDX_W'(phys_sum - (IDX_W+1)'(NCELLS)) : IDX_W'(phys_sum);

  // a scroll moves the base down one row
  assign base_sum = {1'b0, base_r} + (IDX_W+1)'(COLUMNS);
  assign base_adv = (base_sum >= (IDX_W+1)'(NCELLS)) ?
                    IDX_W'(base_sum - (IDX_W+1)'(NCELLS)) : IDX_W'(base_sum);

  assign tab_sum   = {1'b0, col_r} + (COL_W+1)'(TAB_STOP) - (COL_W+1)'(tph_r);
  // 32..127; bytes with the top bit set are negative chars
  assign printable = !ch_r[7] && (ch_r >= tcw_pkg::CH_SPACE);
  assign wrap      = (col_r >= COL_MAX);
  assign c0        = wrap ? '0 : col_r;
  assign p0        = wrap ? '0 : tph_r;
  assign row_full  = (row_r == ROW_LAST);

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_scr_r, out_row_r, out_col_r, out_data_r});

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (NCELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    tph_nxt        = tph_r;
    base_nxt       = base_r;
    last_cell_nxt  = last_cell_r;
    color_nxt      = color_r;
    cmd_nxt        = cmd_r;
    ch_nxt         = ch_r;
    idx_nxt        = idx_r;
    lpos_nxt       = lpos_r;
    rd_nxt         = rd_r;
    go_access_nxt  = go_access_r;
    scr_nxt        = scr_r;
    res_data_nxt   = res_data_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_last_nxt = sweep_last_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_scr_nxt    = out_scr_r;
    ram_we         = 1'b0;
    ram_addr       = sweep_addr_r;
    ram_wdata      = {color_r, tcw_pkg::CH_SPACE};

    // color can be written at any time, it is only sampled while working
    if (cfg_valid) begin
      color_nxt = cfg_data;
    end

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::RESET_BLANK;
        if (sweep_addr_r == IDX_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          ch_nxt    = in_tdata[tcw_pkg::CHAR_W-1:0];
          idx_nxt   = in_tdata[tcw_pkg::CHAR_W +: IDX_W];
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        scr_nxt       = 1'b0;
        res_data_nxt  = last_cell_r;
        go_access_nxt = 1'b0;
        rd_nxt        = 1'b0;
        state_nxt     = S_DONE;
        unique case (cmd_r)
          tcw_pkg::CMD_PUT: begin
            if (ch_r == tcw_pkg::CH_NL) begin
              col_nxt = '0;
              tph_nxt = '0;
              if (row_full) begin
                scr_nxt = 1'b1;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end else if (ch_r == tcw_pkg::CH_CR) begin
              col_nxt = '0;
              tph_nxt = '0;
            end else if (ch_r == tcw_pkg::CH_TAB) begin
              // next tab stop, saturating at the right edge
              if (tab_sum > (COL_W+1)'(COLUMNS)) begin
                col_nxt = COL_MAX;
                tph_nxt = TAB_END;
              end else begin
                col_nxt = COL_W'(tab_sum);
                tph_nxt = '0;
              end
            end else if (printable) begin
              // wrap first; on the last row that scrolls before the write
              if (wrap) begin
                if (row_full) begin
                  scr_nxt = 1'b1;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end
              lpos_nxt      = IDX_W'(((wrap && !row_full) ? row_r + 1'b1 : row_r) * COLUMNS)
                              + IDX_W'(c0);
              col_nxt       = c0 + 1'b1;
              tph_nxt       = (p0 == TAB_LAST) ? '0 : p0 + 1'b1;
              last_cell_nxt = {color_r, ch_r};
              res_data_nxt  = {color_r, ch_r};
              go_access_nxt = 1'b1;
              state_nxt     = S_ACCESS;
            end
          end
          tcw_pkg::CMD_READ: begin
            if (32'(idx_r) >= NCELLS) begin
              res_data_nxt = '0;
            end else begin
              lpos_nxt  = idx_r;
              rd_nxt    = 1'b1;
              state_nxt = S_ACCESS;
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            col_nxt        = '0;
            row_nxt        = '0;
            tph_nxt        = '0;
            base_nxt       = '0;
            sweep_addr_nxt = '0;
            sweep_last_nxt = IDX_LAST;
            state_nxt      = S_BLANK;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
        // scroll: the old top row becomes the new bottom row and is blanked
        if (cmd_r == tcw_pkg::CMD_PUT && scr_nxt) begin
          row_nxt        = ROW_LAST;
          base_nxt       = base_adv;
          sweep_addr_nxt = base_r;
          sweep_last_nxt = IDX_W'(base_r + IDX_W'(COLUMNS - 1));
          state_nxt      = S_BLANK;
        end
      end

      S_BLANK: begin
        ram_we = 1'b1;
        if (sweep_addr_r == sweep_last_r) begin
          state_nxt = go_access_r ? S_ACCESS : S_DONE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + 1'b1;
        end
      end

      S_ACCESS: begin
        ram_addr  = phys_addr;
        ram_we    = !rd_r;
        ram_wdata = last_cell_r;
        state_nxt = rd_r ? S_RDATA : S_DONE;
      end

      S_RDATA: begin
        res_data_nxt = ram_rdata;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_col_nxt   = col_r;
          out_row_nxt   = row_r;
          out_scr_nxt   = scr_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      col_r        <= '0;
      row_r        <= '0;
      tph_r        <= '0;
      base_r       <= '0;
      last_cell_r  <= '0;
      color_r      <= tcw_pkg::RESET_COLOR;
      sweep_addr_r <= '0;
      sweep_last_r <= IDX_LAST;
      go_access_r  <= 1'b0;
      rd_r         <= 1'b0;
      scr_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      tph_r        <= tph_nxt;
      base_r       <= base_nxt;
      last_cell_r  <= last_cell_nxt;
      color_r      <= color_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_last_r <= sweep_last_nxt;
      go_access_r  <= go_access_nxt;
      rd_r         <= rd_nxt;
      scr_r        <= scr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    ch_r       <= ch_nxt;
    idx_r      <= idx_nxt;
    lpos_r     <= lpos_nxt;
    res_data_r <= res_data_nxt;
    out_data_r <= out_data_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_scr_r  <= out_scr_nxt;
  end

endmodule

// File: sv/tcw_checker.sv
module tcw_checker #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  localparam int COL_W   = $clog2(COLUMNS + 1),
  localparam int ROW_W   = $clog2(ROWS),
  localparam int OUT_RAW = tcw_pkg::CELL_W + COL_W + ROW_W + 1,
  localparam int OUT_DW  = ((OUT_RAW + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  localparam int COL_LO = tcw_pkg::CELL_W;
  localparam int ROW_LO = COL_LO + COL_W;
  localparam int SCR_AT = ROW_LO + ROW_W;

  logic [COL_W-1:0] o_col;
  logic [ROW_W-1:0] o_row;
  logic             o_scr;

  assign o_col = out_tdata[COL_LO +: COL_W];
  assign o_row = out_tdata[ROW_LO +: ROW_W];
  assign o_scr = out_tdata[SCR_AT];

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // one command in flight: intake closes right after a beat is taken
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while one is in flight");

  // cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(o_row) <= ROWS - 1) && (32'(o_col) <= COLUMNS))
    else $error("cursor off screen");

  // a scroll leaves the cursor on the bottom row, at column 0 or 1
  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_scr |-> (32'(o_row) == ROWS - 1) && (32'(o_col) <= 1))
    else $error("scroll with cursor away from bottom row start");

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);
